// ----- sv/alc_pkg.sv -----
// ----------------------------------------------------------------------------
// alc_pkg
// Shared types, widths and coefficient tables for the lux calculation.
// ----------------------------------------------------------------------------
package alc_pkg;

  localparam int CNT_W   = 16;
  localparam int SCALE_W = 19;
  localparam int CH_W    = 25;
  localparam int DIVN_W  = 35;
  localparam int Q_W     = 12;
  localparam int CF_W    = 10;
  localparam int PROD_W  = 35;
  localparam int LUX_W   = 21;
  localparam int CAL_W   = 22;
  localparam int X_W     = 29;
  localparam int NBRK    = 7;

  localparam int DIV_STEPS = Q_W;

  // floor(x/200) = floor(floor(x/8) * ceil(2^31/25) / 2^31) for x below 2^29
  localparam int CAL_RECIP_W = 27;
  localparam int CAL_SHIFT   = 31;
  localparam int CALP_W      = X_W - 3 + CAL_RECIP_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [1:0] REG_LOW_GAIN = 2'd0;
  localparam logic [1:0] REG_INT_MODE = 2'd1;
  localparam logic [1:0] REG_PACKAGE  = 2'd2;

  localparam logic [1:0] INT_13MS  = 2'd0;
  localparam logic [1:0] INT_101MS = 2'd1;

  localparam logic [SCALE_W-1:0] SCALE_13MS  = 19'h07517;
  localparam logic [SCALE_W-1:0] SCALE_101MS = 19'h00FE7;
  localparam logic [SCALE_W-1:0] SCALE_UNITY = 19'h00400;

  localparam logic [8:0]  CAL_MUL = 9'd229;
  localparam logic [13:0] CAL_ADD = 14'd9214;
  localparam logic [CAL_RECIP_W-1:0] CAL_RECIP = 27'd85899346;
  localparam logic [13:0] LUX_HALF = 14'd8192;

  localparam logic [Q_W-1:0] BRK_T [NBRK] = '{12'h040, 12'h080, 12'h0C0, 12'h100,
                                              12'h138, 12'h19A, 12'h29A};
  localparam logic [Q_W-1:0] BRK_C [NBRK] = '{12'h043, 12'h085, 12'h0C8, 12'h10A,
                                              12'h14D, 12'h19A, 12'h29A};
  localparam logic [CF_W-1:0] B_T [NBRK] = '{10'h1F2, 10'h214, 10'h23F, 10'h270,
                                             10'h16F, 10'h0D2, 10'h018};
  localparam logic [CF_W-1:0] B_C [NBRK] = '{10'h204, 10'h228, 10'h253, 10'h282,
                                             10'h177, 10'h101, 10'h037};
  localparam logic [CF_W-1:0] M_T [NBRK] = '{10'h1BE, 10'h2D1, 10'h37B, 10'h3FE,
                                             10'h1FC, 10'h0FB, 10'h012};
  localparam logic [CF_W-1:0] M_C [NBRK] = '{10'h1AD, 10'h2C1, 10'h363, 10'h3DF,
                                             10'h1DD, 10'h127, 10'h02B};

  typedef struct packed {
    logic [CH_W-1:0] ch0;
    logic [CH_W-1:0] ch1;
    logic            pk;
    logic            zero;
    logic            sat;
  } item_t;

  typedef struct packed {
    logic [CF_W-1:0] b;
    logic [CF_W-1:0] m;
  } coef_t;

  // first breakpoint at or above the ratio; zeros past the last one
  function automatic coef_t coef_sel(input logic pk, input logic [Q_W-1:0] ratio);
    coef_t c;
    logic  hit;
    c   = '0;
    hit = 1'b0;
    for (int i = 0; i < NBRK; i++) begin
      if (!hit && ratio <= (pk ? BRK_C[i] : BRK_T[i])) begin
        hit = 1'b1;
        c.b = pk ? B_C[i] : B_T[i];
        c.m = pk ? M_C[i] : M_T[i];
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/alc_front.sv -----
// ----------------------------------------------------------------------------
// alc_front
// Config registers, count scaling and ratio-range classification.
// ----------------------------------------------------------------------------
module alc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [1:0]                  cfg_index,
  input  logic [1:0]                  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [alc_pkg::CNT_W-1:0]   broadband_count,
  input  logic [alc_pkg::CNT_W-1:0]   infrared_count,
  input  logic                        q_full,
  output logic                        push,
  output alc_pkg::item_t              push_item
);
  import alc_pkg::*;

  logic               low_gain;
  logic [1:0]         integration_mode;
  logic               package_type;
  logic               fv;
  logic [CH_W-1:0]    ch0;
  logic [CH_W-1:0]    ch1;
  logic               pk;
  logic [SCALE_W-1:0] scale_base;
  logic [SCALE_W-1:0] scale;
  logic [DIVN_W-1:0]  p0;
  logic [DIVN_W-1:0]  p1;
  logic               load;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_gain         <= 1'b1;
      integration_mode <= INT_13MS;
      package_type     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOW_GAIN: low_gain         <= cfg_data[0];
        REG_INT_MODE: integration_mode <= cfg_data;
        REG_PACKAGE:  package_type     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (integration_mode)
      INT_13MS:  scale_base = SCALE_13MS;
      INT_101MS: scale_base = SCALE_101MS;
      default:   scale_base = SCALE_UNITY;
    endcase
    scale = low_gain ? {scale_base[SCALE_W-5:0], 4'b0} : scale_base;
  end

  assign p0 = DIVN_W'(broadband_count) * DIVN_W'(scale);
  assign p1 = DIVN_W'(infrared_count) * DIVN_W'(scale);

  assign push     = fv && !q_full;
  assign in_stall = fv && q_full;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (load) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch0 <= p0[DIVN_W-1:10];
      ch1 <= p1[DIVN_W-1:10];
      pk  <= package_type;
    end
  end

  // sat: ch1 >= 4*ch0, quotient would not fit the divider
  always_comb begin
    push_item.ch0  = ch0;
    push_item.ch1  = ch1;
    push_item.pk   = pk;
    push_item.zero = (ch0 == '0);
    push_item.sat  = ({2'b00, ch1} >= {ch0, 2'b00});
  end

endmodule

// ----- sv/alc_queue.sv -----
// ----------------------------------------------------------------------------
// alc_queue
// Small register queue between front and back.
// ----------------------------------------------------------------------------
module alc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  alc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output alc_pkg::item_t head
);
  import alc_pkg::*;

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr;
  logic [QPTR_W-1:0] rd;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) wr <= wr + 1'b1;
      if (pop)  rd <= rd + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr] <= push_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ----- sv/alc_back.sv -----
// ----------------------------------------------------------------------------
// alc_back
// Ratio divider, coefficient pick, lux and calibrated lux pipeline.
// ----------------------------------------------------------------------------
module alc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  alc_pkg::item_t              head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [alc_pkg::LUX_W-1:0]   lux_value,
  output logic [alc_pkg::CAL_W-1:0]   calibrated_lux
);
  import alc_pkg::*;

  localparam int NS = DIV_STEPS + 5;

  typedef struct packed {
    logic [DIVN_W-1:0] r;
    logic [Q_W-1:0]    q;
    logic [CH_W-1:0]   d;
    logic [CH_W-1:0]   c1;
    logic              pk;
    logic              zero;
    logic              sat;
  } dv_t;

  logic [NS-1:0]     vld;
  logic              en;
  dv_t               dv [DIV_STEPS];
  logic [CH_W-1:0]   cf_ch0;
  logic [CH_W-1:0]   cf_ch1;
  coef_t             cf;
  logic [PROD_W-1:0] pr0;
  logic [PROD_W-1:0] pr1;
  logic [LUX_W-1:0]  lx;
  logic [X_W-1:0]    mx;
  logic [LUX_W-1:0]  mx_lux;
  logic [Q_W:0]      q_inc;
  logic [Q_W-1:0]    ratio;
  logic [PROD_W-1:0] diff;
  logic [PROD_W:0]   rsum;
  logic [CALP_W-1:0] cprod;
  logic [CAL_W-1:0]  cal_q;
  logic [LUX_W-1:0]  cal_lux;

  assign en  = !(vld[NS-1] && out_stall);
  assign pop = en && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], pop};
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    dv_t             src;
    dv_t             nxt;
    logic [DIVN_W+1:0] trial;
    if (g == 0) begin : g_first
      always_comb begin
        src      = '0;
        src.r    = {head.ch1, 10'b0};
        src.d    = head.ch0;
        src.c1   = head.ch1;
        src.pk   = head.pk;
        src.zero = head.zero;
        src.sat  = head.sat;
      end
    end else begin : g_rest
      assign src = dv[g-1];
    end
    assign trial = (DIVN_W+2)'(src.d) << (DIV_STEPS-1-g);
    always_comb begin
      nxt = src;
      if ((DIVN_W+2)'(src.r) >= trial) begin
        nxt.r = DIVN_W'((DIVN_W+2)'(src.r) - trial);
        nxt.q[DIV_STEPS-1-g] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) dv[g] <= nxt;
    end
  end

  always_comb begin
    q_inc = (Q_W+1)'(dv[DIV_STEPS-1].q) + 1'b1;
    if (dv[DIV_STEPS-1].zero)     ratio = '0;
    else if (dv[DIV_STEPS-1].sat) ratio = '1;
    else                          ratio = q_inc[Q_W:1];
  end

  always_comb begin
    diff = (pr0 > pr1) ? (pr0 - pr1) : '0;
    rsum = (PROD_W+1)'(diff) + (PROD_W+1)'(LUX_HALF);
  end

  // divide by 200 as a shift by 3 and a reciprocal multiply for 25
  assign cprod = CALP_W'(mx[X_W-1:3]) * CALP_W'(CAL_RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      cf_ch0  <= dv[DIV_STEPS-1].d;
      cf_ch1  <= dv[DIV_STEPS-1].c1;
      cf      <= coef_sel(dv[DIV_STEPS-1].pk, ratio);
      pr0     <= PROD_W'(cf_ch0) * PROD_W'(cf.b);
      pr1     <= PROD_W'(cf_ch1) * PROD_W'(cf.m);
      lx      <= rsum[14 +: LUX_W];
      mx      <= X_W'(lx) * X_W'(CAL_MUL) + X_W'(CAL_ADD);
      mx_lux  <= lx;
      cal_q   <= cprod[CAL_SHIFT +: CAL_W];
      cal_lux <= mx_lux;
    end
  end

  assign out_valid      = vld[NS-1];
  assign lux_value      = cal_lux;
  assign calibrated_lux = (cal_lux == '0) ? '0 : cal_q;

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(lux_value)))
    else $error("result lost under stall");
  a_pop_only_when_moving: assert property (@(posedge clk) disable iff (rst)
    pop |-> en)
    else $error("pop while pipeline held");
  a_zero_cal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && lux_value == '0) |-> (calibrated_lux == '0))
    else $error("calibrated lux nonzero for zero lux");

endmodule

// ----- sv/ambient_light_lux_calc_top.sv -----
// ----------------------------------------------------------------------------
// ambient_light_lux_calc_top
// Two-channel photodiode lux calculation with calibrated output.
// ----------------------------------------------------------------------------
// channel  signals                                   direction
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data   in
// in       in_valid/in_stall, broadband/infrared      in
// out      out_valid/out_stall, lux_value, calibrated_lux out
//
// One item per cycle sustained unless the output stalls; on the way to a result
// an item passes the front register, queue, 12-step ratio divider, then the
// coefficient, product, lux, calibration multiply and divide-by-200 stages.
// A 4-entry queue separates the scaling front from the back pipeline.
// Synchronous reset; config registers return to gain 1x, 13.7 ms, T package.
// out_stall with out_valid freezes the back pipeline; the front fills the queue.
// ----------------------------------------------------------------------------
module ambient_light_lux_calc_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [1:0]                  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [alc_pkg::CNT_W-1:0]   broadband_count,
  input  logic [alc_pkg::CNT_W-1:0]   infrared_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [alc_pkg::LUX_W-1:0]   lux_value,
  output logic [alc_pkg::CAL_W-1:0]   calibrated_lux
);
  import alc_pkg::*;

  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  item_t push_item;
  item_t head;

  assign cfg_ready = 1'b1;

  alc_front u_front (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .broadband_count, .infrared_count,
    .q_full(full), .push, .push_item
  );

  alc_queue u_queue (
    .clk, .rst, .push, .push_item, .full, .pop, .empty, .head
  );

  alc_back u_back (
    .clk, .rst, .empty, .head, .pop,
    .out_valid, .out_stall, .lux_value, .calibrated_lux
  );

endmodule

// ----- dv/lux_checker.sv -----
// ----------------------------------------------------------------------------
// lux_checker
// Watches the config, input and output channels of the lux calculation,
// predicts lux and calibrated lux per accepted item and compares in order.
// ----------------------------------------------------------------------------
module lux_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [1:0]                 cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [alc_pkg::CNT_W-1:0]  broadband_count,
  input  logic [alc_pkg::CNT_W-1:0]  infrared_count,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [alc_pkg::LUX_W-1:0]  lux_value,
  input  logic [alc_pkg::CAL_W-1:0]  calibrated_lux,
  output int                         fail_count,
  output int                         pending
);
  import alc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LUX_W-1:0] lux;
    logic [CAL_W-1:0] cal;
  } lux_pair_t;

  logic       gain_1x;
  logic [1:0] int_mode;
  logic       pkg_cs;
  lux_pair_t  lux_q[$];

  localparam logic [11:0] BRK_TB [2][NBRK] = '{
    '{12'h040, 12'h080, 12'h0C0, 12'h100, 12'h138, 12'h19A, 12'h29A},
    '{12'h043, 12'h085, 12'h0C8, 12'h10A, 12'h14D, 12'h19A, 12'h29A}};
  localparam logic [9:0] CB_TB [2][NBRK] = '{
    '{10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018},
    '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037}};
  localparam logic [9:0] CM_TB [2][NBRK] = '{
    '{10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012},
    '{10'h1AD, 10'h2C1, 10'h363, 10'h3DF, 10'h1DD, 10'h127, 10'h02B}};

  function automatic lux_pair_t calc_lux(input logic [15:0] c0, input logic [15:0] c1);
    logic [63:0] scl, ch0, ch1, ratio, pos, neg, lux, cal, b, m;
    lux_pair_t r;
    logic hit;
    case (int_mode)
      INT_13MS:  scl = 64'h7517;
      INT_101MS: scl = 64'h0FE7;
      default:   scl = 64'd1024;
    endcase
    if (gain_1x) scl = scl << 4;
    ch0 = (64'(c0) * scl) >> 10;
    ch1 = (64'(c1) * scl) >> 10;
    ratio = 0;
    if (ch0 != 0) ratio = (ch1 << 10) / ch0;
    ratio = (ratio + 1) >> 1;
    b = 0; m = 0; hit = 1'b0;
    for (int i = 0; i < NBRK; i++) begin
      if (!hit && ratio <= 64'(BRK_TB[pkg_cs][i])) begin
        hit = 1'b1;
        b = 64'(CB_TB[pkg_cs][i]);
        m = 64'(CM_TB[pkg_cs][i]);
      end
    end
    pos = ch0 * b;
    neg = ch1 * m;
    lux = (pos > neg) ? pos - neg : 64'd0;
    lux = (lux + 64'd8192) >> 14;
    cal = (lux != 0) ? (lux * 229 + 9214) / 200 : 64'd0;
    r.lux = lux[LUX_W-1:0];
    r.cal = cal[CAL_W-1:0];
    return r;
  endfunction

  assign pending = lux_q.size();

  always @(posedge clk) begin
    lux_pair_t exp_r;
    int        errs;
    errs = 0;
    if (rst) begin
      gain_1x    <= 1'b1;
      int_mode   <= INT_13MS;
      pkg_cs     <= 1'b0;
      fail_count <= 0;
      lux_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOW_GAIN: gain_1x  <= cfg_data[0];
          REG_INT_MODE: int_mode <= cfg_data;
          REG_PACKAGE:  pkg_cs   <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        lux_q.push_back(calc_lux(broadband_count, infrared_count));
      if (out_valid && !out_stall) begin
        if (lux_q.size() == 0) begin
          $display("%0t: unexpected item lux=%0d cal=%0d", $time, lux_value,
                   calibrated_lux);
          errs++;
        end else begin
          exp_r = lux_q.pop_front();
          if (exp_r.lux !== lux_value) begin
            $display("%0t: lux_value expected %0d actual %0d", $time, exp_r.lux,
                     lux_value);
            errs++;
          end
          if (exp_r.cal !== calibrated_lux) begin
            $display("%0t: calibrated_lux expected %0d actual %0d", $time,
                     exp_r.cal, calibrated_lux);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// ----- dv/tb_ambient_light_lux_calc_top.sv -----
// ----------------------------------------------------------------------------
// tb_ambient_light_lux_calc_top
// Drives count pairs and config settings into the lux block under random
// and long stalls; lux_checker does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_ambient_light_lux_calc_top;
  import alc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [1:0]       cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CNT_W-1:0] broadband_count = '0;
  logic [CNT_W-1:0] infrared_count = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [LUX_W-1:0] lux_value;
  logic [CAL_W-1:0] calibrated_lux;
  int               fail_count;
  int               pending;
  int               send_idle_pct = 30;
  int               recv_idle_pct = 57;
  bit               hold_rx = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ambient_light_lux_calc_top i_dut (.*);

  lux_checker i_chk (.*);

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // receiver stall: random, or a long hold-off when requested
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_rx || ($urandom_range(99) < recv_idle_pct);
  end

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_mode(input logic gain, input logic [1:0] im, input logic pk);
    settle();
    write_reg(REG_LOW_GAIN, {1'b0, gain});
    write_reg(REG_INT_MODE, im);
    write_reg(REG_PACKAGE, {1'b0, pk});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one item; idle gaps before it, valid held until accepted
  task automatic send_counts(input logic [15:0] c0, input logic [15:0] c1);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    broadband_count <= c0;
    infrared_count  <= c1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_rand();
    logic [15:0] c0, c1;
    c0 = ($urandom_range(3) == 0) ? 16'($urandom_range(255)) : 16'($urandom);
    case ($urandom_range(3))
      0: c1 = 16'($urandom);
      1: c1 = c0 >> $urandom_range(4);
      2: c1 = 16'((32'(c0) * $urandom_range(1000)) / 1000);
      default: c1 = 16'($urandom_range(255));
    endcase
    send_counts(c0, c1);
  endtask

  task automatic directed();
    send_counts(16'h0000, 16'h0000);
    send_counts(16'h0000, 16'hFFFF);
    send_counts(16'hFFFF, 16'h0000);
    send_counts(16'hFFFF, 16'hFFFF);
    send_counts(16'hFFFF, 16'h7FFF);
    send_counts(16'h5555, 16'hAAAA);
    send_counts(16'hAAAA, 16'h5555);
    send_counts(16'h1000, 16'h0200);
    send_counts(16'h1000, 16'h0400);
    send_counts(16'h1000, 16'h0600);
    send_counts(16'h1000, 16'h0800);
    send_counts(16'h1000, 16'h09C0);
    send_counts(16'h1000, 16'h0CD0);
    send_counts(16'h1000, 16'h14D0);
    send_counts(16'h1000, 16'h14E0);
    send_counts(16'h0001, 16'h0001);
    send_counts(16'h0001, 16'h0000);
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed();
    set_mode(1'b0, 2'd2, 1'b1);
    directed();
    set_mode(1'b1, 2'd3, 1'b0);
    directed();
    set_mode(1'b0, 2'd1, 1'b1);
    directed();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 57;
        recv_idle_pct = 30;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_mode(1'($urandom), 2'($urandom), 1'($urandom));
      if (ph == 6) hold_rx = 1'b1;
      for (int n = 0; n < 100; n++) begin
        send_rand();
      end
      in_valid <= 1'b0;
      if (ph == 4) settle();
    end
    settle();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // long receiver hold-off is timed in its own process
  initial begin
    wait (hold_rx);
    repeat (300) @(posedge clk);
    hold_rx = 1'b0;
  end
endmodule

// ----- files.f -----
sv/alc_pkg.sv
sv/alc_front.sv
sv/alc_queue.sv
sv/alc_back.sv
sv/ambient_light_lux_calc_top.sv
dv/lux_checker.sv
dv/tb_ambient_light_lux_calc_top.sv
